// ----- sv/bbcg_pkg.sv -----
// Shared types, constants and the CORDIC angle table for the coefficient generator.
`default_nettype none
package bbcg_pkg;
    // Field and datapath widths.
    localparam int FS_W   = 18;
    localparam int CUT_W  = 17;
    localparam int PH_W   = 32;
    localparam int CW     = 33;
    localparam int XY_W   = 32;
    localparam int NUM_W  = 64;
    localparam int OUT_W  = 32;
    localparam int LANES  = 4;

    // Divider lane assignment.
    localparam int LANE_B0 = 0;
    localparam int LANE_B1 = 1;
    localparam int LANE_A1 = 2;
    localparam int LANE_A2 = 3;

    // Numeric constants.
    localparam logic [FS_W-1:0] FS_RESET  = 18'd48000;
    localparam logic [31:0]     PI_Q30    = 32'hC90FDAA2;
    localparam logic [29:0]     INV2Q_Q30 = 30'd759250125;

    typedef logic signed [CW-1:0] cval_t;

    localparam cval_t X_INIT = 33'sd1073741824;

    // Control that travels alongside each word.
    typedef struct packed {
        logic valid;
        logic bad;
        logic first;
        logic highpass;
    } tag_t;

    // One finished result word.
    typedef struct packed {
        logic [OUT_W-1:0] b0;
        logic [OUT_W-1:0] b1;
        logic [OUT_W-1:0] b2;
        logic [OUT_W-1:0] a1;
        logic [OUT_W-1:0] a2;
        logic             bad;
    } res_t;

    // atan(2^-i) in Q2.30, truncated.
    function automatic cval_t atan_entry(input int i);
        cval_t v;
        case (i)
            0:       v = 33'sh03243F6A8;
            1:       v = 33'sh01DAC6705;
            2:       v = 33'sh00FADBAFC;
            3:       v = 33'sh007F56EA6;
            4:       v = 33'sh003FEAB76;
            5:       v = 33'sh001FFD55B;
            6:       v = 33'sh000FFFAAA;
            7:       v = 33'sh0007FFF55;
            8:       v = 33'sh0003FFFEA;
            9:       v = 33'sh0001FFFFD;
            default:
            begin
                if (i < 30)
                begin
                    v = (cval_t'(1) <<< (30 - i)) - cval_t'(1);
                end
                else
                begin
                    v = '0;
                end
            end
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

// ----- sv/bbcg_phase_cell.sv -----
// One restoring step of the cutoff-over-sample-rate phase divider.
`default_nettype none
module bbcg_phase_cell (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              en,
    input  wire [bbcg_pkg::FS_W-1:0]         fs,
    input  wire bbcg_pkg::tag_t              tag_in,
    input  wire [bbcg_pkg::FS_W-1:0]         rem_in,
    input  wire [bbcg_pkg::PH_W-1:0]         quo_in,
    output bbcg_pkg::tag_t                   tag_out,
    output logic [bbcg_pkg::FS_W-1:0]        rem_out,
    output logic [bbcg_pkg::PH_W-1:0]        quo_out
);
    bbcg_pkg::tag_t                   tag_reg;
    logic [bbcg_pkg::FS_W-1:0]        rem_reg;
    logic [bbcg_pkg::FS_W-1:0]        rem_next;
    logic [bbcg_pkg::PH_W-1:0]        quo_reg;
    logic [bbcg_pkg::PH_W-1:0]        quo_next;
    logic [bbcg_pkg::FS_W:0]          trial;
    logic [bbcg_pkg::FS_W:0]          diff;
    logic                             take;

    // Shift in a zero dividend bit and subtract when the divisor fits.
    assign trial    = {rem_in, 1'b0};
    assign diff     = trial - {1'b0, fs};
    assign take     = trial >= {1'b0, fs};
    assign rem_next = take ? diff[bbcg_pkg::FS_W-1:0] : trial[bbcg_pkg::FS_W-1:0];
    assign quo_next = {quo_in[bbcg_pkg::PH_W-2:0], take};

    // Control register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else if (en)
        begin
            tag_reg <= tag_in;
        end
    end

    // Data registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign tag_out = tag_reg;
    assign rem_out = rem_reg;
    assign quo_out = quo_reg;
endmodule
`default_nettype wire

// ----- sv/bbcg_cordic_cell.sv -----
// One rotation-mode CORDIC micro-rotation with its own shift and angle.
`default_nettype none
module bbcg_cordic_cell #(
    parameter int IDX = 0
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   en,
    input  wire bbcg_pkg::tag_t   tag_in,
    input  wire bbcg_pkg::cval_t  x_in,
    input  wire bbcg_pkg::cval_t  y_in,
    input  wire bbcg_pkg::cval_t  z_in,
    output bbcg_pkg::tag_t        tag_out,
    output bbcg_pkg::cval_t       x_out,
    output bbcg_pkg::cval_t       y_out,
    output bbcg_pkg::cval_t       z_out
);
    bbcg_pkg::tag_t   tag_reg;
    bbcg_pkg::cval_t  x_reg;
    bbcg_pkg::cval_t  y_reg;
    bbcg_pkg::cval_t  z_reg;
    bbcg_pkg::cval_t  x_next;
    bbcg_pkg::cval_t  y_next;
    bbcg_pkg::cval_t  z_next;
    bbcg_pkg::cval_t  dx;
    bbcg_pkg::cval_t  dy;
    bbcg_pkg::cval_t  ang;

    // Arithmetic shifts floor toward minus infinity.
    assign dx  = y_in >>> IDX;
    assign dy  = x_in >>> IDX;
    assign ang = bbcg_pkg::atan_entry(IDX);

    // Rotate toward a zero residual angle.
    always_comb
    begin
        if (!z_in[bbcg_pkg::CW-1])
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ang;
        end
        else
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ang;
        end
    end

    // Control register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else if (en)
        begin
            tag_reg <= tag_in;
        end
    end

    // Data registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign tag_out = tag_reg;
    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign z_out   = z_reg;
endmodule
`default_nettype wire

// ----- sv/bbcg_div_cell.sv -----
// One restoring quotient step for all coefficient lanes over a shared divisor.
`default_nettype none
module bbcg_div_cell #(
    parameter int QW = 31
) (
    input  wire                                                    clk,
    input  wire                                                    rst_n,
    input  wire                                                    en,
    input  wire bbcg_pkg::tag_t                                    tag_in,
    input  wire [bbcg_pkg::NUM_W-1:0]                              den_in,
    input  wire [bbcg_pkg::LANES-1:0][bbcg_pkg::NUM_W-1:0]         rem_in,
    input  wire [bbcg_pkg::LANES-1:0][1:0]                         feed_in,
    input  wire [bbcg_pkg::LANES-1:0][QW-1:0]                      quo_in,
    input  wire [bbcg_pkg::LANES-1:0]                              neg_in,
    output bbcg_pkg::tag_t                                         tag_out,
    output logic [bbcg_pkg::NUM_W-1:0]                             den_out,
    output logic [bbcg_pkg::LANES-1:0][bbcg_pkg::NUM_W-1:0]        rem_out,
    output logic [bbcg_pkg::LANES-1:0][1:0]                        feed_out,
    output logic [bbcg_pkg::LANES-1:0][QW-1:0]                     quo_out,
    output logic [bbcg_pkg::LANES-1:0]                             neg_out
);
    bbcg_pkg::tag_t                                   tag_reg;
    logic [bbcg_pkg::NUM_W-1:0]                       den_reg;
    logic [bbcg_pkg::LANES-1:0][bbcg_pkg::NUM_W-1:0]  rem_reg;
    logic [bbcg_pkg::LANES-1:0][bbcg_pkg::NUM_W-1:0]  rem_next;
    logic [bbcg_pkg::LANES-1:0][1:0]                  feed_reg;
    logic [bbcg_pkg::LANES-1:0][1:0]                  feed_next;
    logic [bbcg_pkg::LANES-1:0][QW-1:0]               quo_reg;
    logic [bbcg_pkg::LANES-1:0][QW-1:0]               quo_next;
    logic [bbcg_pkg::LANES-1:0]                       neg_reg;

    // Each lane brings in its next dividend bit and subtracts when it can.
    for (genvar l = 0; l < bbcg_pkg::LANES; l++)
    begin : g_lane
        logic [bbcg_pkg::NUM_W:0] trial;
        logic [bbcg_pkg::NUM_W:0] diff;
        logic                     take;

        assign trial         = {rem_in[l], feed_in[l][1]};
        assign diff          = trial - {1'b0, den_in};
        assign take          = trial >= {1'b0, den_in};
        assign rem_next[l]   = take ? diff[bbcg_pkg::NUM_W-1:0]
                                    : trial[bbcg_pkg::NUM_W-1:0];
        assign feed_next[l]  = {feed_in[l][0], 1'b0};
        assign quo_next[l]   = {quo_in[l][QW-2:0], take};
    end

    // Control register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else if (en)
        begin
            tag_reg <= tag_in;
        end
    end

    // Data registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg  <= den_in;
            rem_reg  <= rem_next;
            feed_reg <= feed_next;
            quo_reg  <= quo_next;
            neg_reg  <= neg_in;
        end
    end

    assign tag_out  = tag_reg;
    assign den_out  = den_reg;
    assign rem_out  = rem_reg;
    assign feed_out = feed_reg;
    assign quo_out  = quo_reg;
    assign neg_out  = neg_reg;
endmodule
`default_nettype wire

// ----- sv/butterworth_biquad_coef_gen.sv -----
// Throughput: one request per cycle, set by the fully pipelined chains of divider cells,
// CORDIC cells and coefficient divider cells, each cell one register stage.
// A two-word output buffer holds results; input stalls only when both words are held.
// Reset clears all valid bits and the buffer, and sets the sample rate to 48000 Hz.
`default_nettype none
module butterworth_biquad_coef_gen #(
    parameter int COEF_WIDTH    = 32,
    parameter int CORDIC_STAGES = 24
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire [bbcg_pkg::FS_W-1:0]         cfg_data,
    input  wire                              in_valid,
    output logic                             in_ready,
    input  wire                              func,
    input  wire [bbcg_pkg::CUT_W-1:0]        cutoff_hz,
    input  wire                              first_order,
    output logic                             out_valid,
    input  wire                              out_ready,
    output logic signed [bbcg_pkg::OUT_W-1:0] b0_coef,
    output logic signed [bbcg_pkg::OUT_W-1:0] b1_coef,
    output logic signed [bbcg_pkg::OUT_W-1:0] b2_coef,
    output logic signed [bbcg_pkg::OUT_W-1:0] a1_coef,
    output logic signed [bbcg_pkg::OUT_W-1:0] a2_coef,
    output logic                             bad_request
);
    localparam int QW    = COEF_WIDTH - 1;
    localparam int PH_W  = bbcg_pkg::PH_W;
    localparam int FS_W  = bbcg_pkg::FS_W;
    localparam int NUM_W = bbcg_pkg::NUM_W;
    localparam int LANES = bbcg_pkg::LANES;
    localparam int XY_W  = bbcg_pkg::XY_W;

    logic                       en;
    logic [FS_W-1:0]            fs_reg;
    logic                       in_bad;

    // Sample rate register.
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fs_reg <= bbcg_pkg::FS_RESET;
        end
        else if (cfg_valid)
        begin
            fs_reg <= cfg_data;
        end
    end

    // Reject a zero cutoff or one at or above Nyquist.
    assign in_bad = (cutoff_hz == '0) || ({cutoff_hz, 1'b0} >= fs_reg);

    // Phase divider chain: floor(f * 2^32 / fs).
    bbcg_pkg::tag_t             ph_tag [0:PH_W];
    logic [FS_W-1:0]            ph_rem [0:PH_W];
    logic [PH_W-1:0]            ph_quo [0:PH_W];

    assign ph_tag[0] = '{valid: in_valid, bad: in_bad, first: first_order, highpass: func};
    assign ph_rem[0] = FS_W'(cutoff_hz);
    assign ph_quo[0] = '0;

    for (genvar i = 0; i < PH_W; i++)
    begin : g_phase
        bbcg_phase_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .fs      (fs_reg),
            .tag_in  (ph_tag[i]),
            .rem_in  (ph_rem[i]),
            .quo_in  (ph_quo[i]),
            .tag_out (ph_tag[i+1]),
            .rem_out (ph_rem[i+1]),
            .quo_out (ph_quo[i+1])
        );
    end

    // Half angle: phase in turns times pi.
    bbcg_pkg::tag_t             m_tag_reg;
    logic [31:0]                h_reg;
    logic [63:0]                h_prod;

    assign h_prod = 64'(ph_quo[PH_W]) * 64'(bbcg_pkg::PI_Q30);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tag_reg <= '0;
        end
        else if (en)
        begin
            m_tag_reg <= ph_tag[PH_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_reg <= h_prod[63:32];
        end
    end

    // CORDIC chain.
    bbcg_pkg::tag_t             c_tag [0:CORDIC_STAGES];
    bbcg_pkg::cval_t            c_x   [0:CORDIC_STAGES];
    bbcg_pkg::cval_t            c_y   [0:CORDIC_STAGES];
    bbcg_pkg::cval_t            c_z   [0:CORDIC_STAGES];

    assign c_tag[0] = m_tag_reg;
    assign c_x[0]   = bbcg_pkg::X_INIT;
    assign c_y[0]   = '0;
    assign c_z[0]   = bbcg_pkg::cval_t'({1'b0, h_reg});

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cordic
        bbcg_cordic_cell #(
            .IDX (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .tag_in  (c_tag[i]),
            .x_in    (c_x[i]),
            .y_in    (c_y[i]),
            .z_in    (c_z[i]),
            .tag_out (c_tag[i+1]),
            .x_out   (c_x[i+1]),
            .y_out   (c_y[i+1]),
            .z_out   (c_z[i+1])
        );
    end

    // Clamp to non-negative and form the products.
    bbcg_pkg::tag_t             p_tag_reg;
    logic [XY_W-1:0]            p_x_reg;
    logic [XY_W-1:0]            p_y_reg;
    logic [63:0]                p_xx_reg;
    logic [63:0]                p_yy_reg;
    logic [63:0]                p_xy_reg;
    logic [XY_W-1:0]            cx;
    logic [XY_W-1:0]            cy;
    bbcg_pkg::cval_t            x_last;
    bbcg_pkg::cval_t            y_last;

    assign x_last = c_x[CORDIC_STAGES];
    assign y_last = c_y[CORDIC_STAGES];
    assign cx = x_last[bbcg_pkg::CW-1] ? '0 : x_last[XY_W-1:0];
    assign cy = y_last[bbcg_pkg::CW-1] ? '0 : y_last[XY_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_tag_reg <= '0;
        end
        else if (en)
        begin
            p_tag_reg <= c_tag[CORDIC_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_x_reg  <= cx;
            p_y_reg  <= cy;
            p_xx_reg <= 64'(cx) * 64'(cx);
            p_yy_reg <= 64'(cy) * 64'(cy);
            p_xy_reg <= 64'(cx) * 64'(cy);
        end
    end

    // Cross term T, about sqrt(2) X Y.
    bbcg_pkg::tag_t             t_tag_reg;
    logic [XY_W-1:0]            t_x_reg;
    logic [XY_W-1:0]            t_y_reg;
    logic [63:0]                t_xx_reg;
    logic [63:0]                t_yy_reg;
    logic [63:0]                t_t_reg;
    logic [63:0]                t_prod;

    assign t_prod = 64'(p_xy_reg[63:30]) * 64'(bbcg_pkg::INV2Q_Q30);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_tag_reg <= '0;
        end
        else if (en)
        begin
            t_tag_reg <= p_tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_x_reg  <= p_x_reg;
            t_y_reg  <= p_y_reg;
            t_xx_reg <= p_xx_reg;
            t_yy_reg <= p_yy_reg;
            t_t_reg  <= t_prod >> 29;
        end
    end

    // Divisor, numerators and signs for each lane.
    bbcg_pkg::tag_t                   s_tag_reg;
    logic [NUM_W-1:0]                 s_den_reg;
    logic [LANES-1:0][NUM_W-1:0]      s_rem_reg;
    logic [LANES-1:0][1:0]            s_feed_reg;
    logic [LANES-1:0]                 s_neg_reg;
    logic [NUM_W-1:0]                 den_next;
    logic [LANES-1:0][NUM_W-1:0]      num_next;
    logic [LANES-1:0]                 neg_next;
    logic [NUM_W-1:0]                 sum_d;
    logic [NUM_W-1:0]                 g1;
    logic [NUM_W-1:0]                 g2;

    assign sum_d = t_xx_reg + t_yy_reg;
    assign g1    = t_tag_reg.highpass ? NUM_W'(t_x_reg) : NUM_W'(t_y_reg);
    assign g2    = t_tag_reg.highpass ? t_xx_reg : t_yy_reg;

    always_comb
    begin
        if (t_tag_reg.first)
        begin
            den_next                     = NUM_W'(t_x_reg) + NUM_W'(t_y_reg);
            num_next[bbcg_pkg::LANE_B0]  = g1;
            neg_next[bbcg_pkg::LANE_B0]  = 1'b0;
            num_next[bbcg_pkg::LANE_B1]  = g1;
            neg_next[bbcg_pkg::LANE_B1]  = t_tag_reg.highpass;
            if (t_x_reg >= t_y_reg)
            begin
                num_next[bbcg_pkg::LANE_A1] = NUM_W'(t_x_reg - t_y_reg);
                neg_next[bbcg_pkg::LANE_A1] = 1'b0;
            end
            else
            begin
                num_next[bbcg_pkg::LANE_A1] = NUM_W'(t_y_reg - t_x_reg);
                neg_next[bbcg_pkg::LANE_A1] = 1'b1;
            end
            num_next[bbcg_pkg::LANE_A2]  = '0;
            neg_next[bbcg_pkg::LANE_A2]  = 1'b0;
        end
        else
        begin
            den_next                     = sum_d + t_t_reg;
            num_next[bbcg_pkg::LANE_B0]  = g2;
            neg_next[bbcg_pkg::LANE_B0]  = 1'b0;
            num_next[bbcg_pkg::LANE_B1]  = g2 << 1;
            neg_next[bbcg_pkg::LANE_B1]  = t_tag_reg.highpass;
            if (t_xx_reg >= t_yy_reg)
            begin
                num_next[bbcg_pkg::LANE_A1] = (t_xx_reg - t_yy_reg) << 1;
                neg_next[bbcg_pkg::LANE_A1] = 1'b0;
            end
            else
            begin
                num_next[bbcg_pkg::LANE_A1] = (t_yy_reg - t_xx_reg) << 1;
                neg_next[bbcg_pkg::LANE_A1] = 1'b1;
            end
            num_next[bbcg_pkg::LANE_A2]  = sum_d - t_t_reg;
            neg_next[bbcg_pkg::LANE_A2]  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tag_reg <= '0;
        end
        else if (en)
        begin
            s_tag_reg <= t_tag_reg;
        end
    end

    // The top dividend bits start the remainder; the last two are fed in.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_den_reg <= den_next;
            s_neg_reg <= neg_next;
            for (int l = 0; l < LANES; l++)
            begin
                s_rem_reg[l]  <= num_next[l] >> 2;
                s_feed_reg[l] <= num_next[l][1:0];
            end
        end
    end

    // Coefficient divider chain.
    bbcg_pkg::tag_t                   d_tag  [0:QW];
    logic [NUM_W-1:0]                 d_den  [0:QW];
    logic [LANES-1:0][NUM_W-1:0]      d_rem  [0:QW];
    logic [LANES-1:0][1:0]            d_feed [0:QW];
    logic [LANES-1:0][QW-1:0]         d_quo  [0:QW];
    logic [LANES-1:0]                 d_neg  [0:QW];

    assign d_tag[0]  = s_tag_reg;
    assign d_den[0]  = s_den_reg;
    assign d_rem[0]  = s_rem_reg;
    assign d_feed[0] = s_feed_reg;
    assign d_quo[0]  = '0;
    assign d_neg[0]  = s_neg_reg;

    for (genvar i = 0; i < QW; i++)
    begin : g_div
        bbcg_div_cell #(
            .QW (QW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .tag_in   (d_tag[i]),
            .den_in   (d_den[i]),
            .rem_in   (d_rem[i]),
            .feed_in  (d_feed[i]),
            .quo_in   (d_quo[i]),
            .neg_in   (d_neg[i]),
            .tag_out  (d_tag[i+1]),
            .den_out  (d_den[i+1]),
            .rem_out  (d_rem[i+1]),
            .feed_out (d_feed[i+1]),
            .quo_out  (d_quo[i+1]),
            .neg_out  (d_neg[i+1])
        );
    end

    // Round half away from zero on the magnitude, then apply the sign.
    logic [LANES-1:0][bbcg_pkg::OUT_W-1:0] lane_val;

    for (genvar l = 0; l < LANES; l++)
    begin : g_round
        logic [QW:0]                   msum;
        logic [COEF_WIDTH-1:0]         mag;
        logic signed [COEF_WIDTH-1:0]  sval;

        assign msum        = {1'b0, d_quo[QW][l]} + (QW+1)'(1);
        assign mag         = {1'b0, msum[QW:1]};
        assign sval        = d_neg[QW][l] ? signed'(~mag + 1'b1) : signed'(mag);
        assign lane_val[l] = bbcg_pkg::OUT_W'(sval);
    end

    bbcg_pkg::tag_t             last_tag;
    bbcg_pkg::res_t             push_word;

    assign last_tag = d_tag[QW];

    always_comb
    begin
        if (last_tag.bad)
        begin
            push_word     = '0;
            push_word.bad = 1'b1;
        end
        else
        begin
            push_word.b0  = lane_val[bbcg_pkg::LANE_B0];
            push_word.b1  = lane_val[bbcg_pkg::LANE_B1];
            push_word.b2  = last_tag.first ? '0 : lane_val[bbcg_pkg::LANE_B0];
            push_word.a1  = lane_val[bbcg_pkg::LANE_A1];
            push_word.a2  = lane_val[bbcg_pkg::LANE_A2];
            push_word.bad = 1'b0;
        end
    end

    // Two-word output buffer; the pipeline moves while it has room.
    logic [1:0]                 cnt_reg;
    logic [1:0]                 cnt_next;
    bbcg_pkg::res_t             head_reg;
    bbcg_pkg::res_t             head_next;
    bbcg_pkg::res_t             spare_reg;
    bbcg_pkg::res_t             spare_next;
    logic                       push;
    logic                       pop;

    assign en   = (cnt_reg != 2'd2);
    assign push = en && last_tag.valid;
    assign pop  = (cnt_reg != 2'd0) && out_ready;

    always_comb
    begin
        cnt_next   = cnt_reg;
        head_next  = head_reg;
        spare_next = spare_reg;
        case (cnt_reg)
            2'd0:
            begin
                if (push)
                begin
                    head_next = push_word;
                    cnt_next  = 2'd1;
                end
            end
            2'd1:
            begin
                if (push && pop)
                begin
                    head_next = push_word;
                end
                else if (push)
                begin
                    spare_next = push_word;
                    cnt_next   = 2'd2;
                end
                else if (pop)
                begin
                    cnt_next = 2'd0;
                end
            end
            2'd2:
            begin
                if (pop)
                begin
                    head_next = spare_reg;
                    cnt_next  = 2'd1;
                end
            end
            default:
            begin
                cnt_next = 2'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg  <= head_next;
        spare_reg <= spare_next;
    end

    // Ports.
    assign in_ready    = en;
    assign out_valid   = (cnt_reg != 2'd0);
    assign b0_coef     = head_reg.b0;
    assign b1_coef     = head_reg.b1;
    assign b2_coef     = head_reg.b2;
    assign a1_coef     = head_reg.a1;
    assign a2_coef     = head_reg.a2;
    assign bad_request = head_reg.bad;
endmodule
`default_nettype wire

// ----- sv/bbcg_checker.sv -----
// Port-level checks for the coefficient generator, bound to the top level.
`default_nettype none
module bbcg_checker (
    input wire                               clk,
    input wire                               rst_n,
    input wire                               cfg_valid,
    input wire                               cfg_ready,
    input wire                               in_ready,
    input wire                               out_valid,
    input wire                               out_ready,
    input wire [bbcg_pkg::OUT_W-1:0]         b0_coef,
    input wire [bbcg_pkg::OUT_W-1:0]         b1_coef,
    input wire [bbcg_pkg::OUT_W-1:0]         b2_coef,
    input wire [bbcg_pkg::OUT_W-1:0]         a1_coef,
    input wire [bbcg_pkg::OUT_W-1:0]         a2_coef,
    input wire                               bad_request
);
    // Input stalls only while a result word is waiting.
    a_stall_has_word: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no result waiting");

    // A rejected request carries all-zero coefficients.
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && bad_request) |->
            (b0_coef == '0 && b1_coef == '0 && b2_coef == '0 &&
             a1_coef == '0 && a2_coef == '0))
        else $error("rejected request with nonzero coefficients");

    // A stalled result word holds b0, a1 and the bad flag.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(b0_coef) && $stable(a1_coef) && $stable(bad_request)))
        else $error("result word changed while stalled");

    // The configuration port never back-pressures.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");
endmodule

bind butterworth_biquad_coef_gen bbcg_checker u_bbcg_checker (.*);
`default_nettype wire
